// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/dbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

   localparam int PIX_W = 12;

   localparam logic [23:0] RST_INV_FOCAL_X = 24'd29065;
   localparam logic [23:0] RST_INV_FOCAL_Y = 24'd28903;
   localparam logic [15:0] RST_CENTER_X    = 16'd4840;
   localparam logic [15:0] RST_CENTER_Y    = 16'd3179;
   localparam logic [31:0] RST_MIN_DEPTH   = 32'd32768;
   localparam logic [15:0] RST_DEPTH_SCALE = 16'd6554;
   localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;

   // z used for x and y when the depth is invalid, 1.0 in q16.16
   localparam logic [31:0] UNIT_Z = 32'd65536;

   typedef enum logic [1:0] {
      COLOR_BGR  = 2'd0,
      COLOR_RGB  = 2'd1,
      COLOR_GRAY = 2'd2,
      COLOR_RSVD = 2'd3
   } color_mode_type;

   localparam color_mode_type RST_COLOR_MODE = COLOR_BGR;

   typedef enum logic [2:0] {
      CSR_INV_FOCAL_X = 3'd0,
      CSR_INV_FOCAL_Y = 3'd1,
      CSR_CENTER_X    = 3'd2,
      CSR_CENTER_Y    = 3'd3,
      CSR_MIN_DEPTH   = 3'd4,
      CSR_DEPTH_SCALE = 3'd5,
      CSR_IMAGE_WIDTH = 3'd6,
      CSR_COLOR_MODE  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZMUL,
      ST_ZCMP,
      ST_OFFSET,
      ST_MUL,
      ST_PROD,
      ST_SAT,
      ST_LOAD
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_ZMUL,
      OP_ZCMP,
      OP_OFFSET,
      OP_MUL,
      OP_PROD,
      OP_SAT,
      OP_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   axis_y;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: src/depth_pixel_backprojection_core.sv
// Depth pixel backprojection core.
// Pixels enter on the req_ stream in raster order; req_tuser marks the first
// pixel of a frame and clears the column and row counters. Each pixel yields
// one point on the rsp_ stream: position, X, Y, Z in q16.16 metres, a depth
// valid flag in rsp_tuser and the reordered color bytes.
// Camera registers are written through the csr_ channel, one transfer per
// register; csr_ready is always high. Write them only while the core is idle.
// A pixel is carried through to idle before the next transfer can be taken:
// one sequencer walks a single datapath through the depth multiply, the
// threshold compare, then offset, two multiply steps and saturation for X and
// again for Y, loads the output register and returns to idle. The next pixel
// is taken while a finished point still waits in the output register; if
// rsp_tready stays low the core stalls before its load step with req_tready low.
// Synchronous reset restores the register defaults, zeroes the counters and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module depth_pixel_backprojection_core #(
   parameter int COORD_BITS = 12
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [39:0]  req_tdata,   // depth_raw, chan_zero, chan_one, chan_two
   input  wire  [0:0]   req_tuser,   // first_of_frame
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [143:0] rsp_tdata,   // pixel_col, pixel_row, x_pos, y_pos, z_pos,
                                     // red, green, blue
   output logic [0:0]   rsp_tuser,   // z_valid
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_data
);

   dbp_pkg::cmd_type    cmd;
   dbp_pkg::status_type status;

   assign csr_ready = 1'b1;

   dbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dbp_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_SAME(a_load_when_free, clock, reset, cmd.op == dbp_pkg::OP_LOAD, status.out_free)
   `ASSERT_NEXT(a_drain_clears, clock, reset,
      rsp_tvalid && rsp_tready && cmd.op != dbp_pkg::OP_LOAD, !rsp_tvalid)

endmodule

`default_nettype wire

// File: src/dbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dbp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  dbp_pkg::status_type  status,
   output dbp_pkg::cmd_type     cmd
);

   dbp_pkg::state_type state_ff, state_in;
   logic               axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbp_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      req_tready = 1'b0;
      cmd.op     = dbp_pkg::OP_NONE;
      cmd.axis_y = axis_ff;
      unique case (state_ff)
         dbp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            axis_in    = 1'b0;
            if (req_tvalid) begin
               cmd.op   = dbp_pkg::OP_CAPTURE;
               state_in = dbp_pkg::ST_ZMUL;
            end
         end
         dbp_pkg::ST_ZMUL: begin
            cmd.op   = dbp_pkg::OP_ZMUL;
            state_in = dbp_pkg::ST_ZCMP;
         end
         dbp_pkg::ST_ZCMP: begin
            cmd.op   = dbp_pkg::OP_ZCMP;
            state_in = dbp_pkg::ST_OFFSET;
         end
         dbp_pkg::ST_OFFSET: begin
            cmd.op   = dbp_pkg::OP_OFFSET;
            state_in = dbp_pkg::ST_MUL;
         end
         dbp_pkg::ST_MUL: begin
            cmd.op   = dbp_pkg::OP_MUL;
            state_in = dbp_pkg::ST_PROD;
         end
         dbp_pkg::ST_PROD: begin
            cmd.op   = dbp_pkg::OP_PROD;
            state_in = dbp_pkg::ST_SAT;
         end
         dbp_pkg::ST_SAT: begin
            cmd.op = dbp_pkg::OP_SAT;
            if (axis_ff) begin
               state_in = dbp_pkg::ST_LOAD;
            end else begin
               axis_in  = 1'b1;
               state_in = dbp_pkg::ST_OFFSET;
            end
         end
         dbp_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.op   = dbp_pkg::OP_LOAD;
               state_in = dbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dbp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/dbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dbp_datapath #(
   parameter int COORD_BITS = 12
) (
   input  wire                  clock,
   input  wire                  reset,
   input  dbp_pkg::cmd_type     cmd,
   output dbp_pkg::status_type  status,
   input  wire  [39:0]          req_tdata,
   input  wire  [0:0]           req_tuser,
   input  wire                  csr_valid,
   input  wire  [2:0]           csr_index,
   input  wire  [31:0]          csr_data,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [143:0]         rsp_tdata,
   output logic [0:0]           rsp_tuser
);

   localparam int OFF_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
   localparam int M_W   = OFF_W + 32;
   localparam int PLO_W = 56;
   localparam int PHI_W = OFF_W + 24;
   localparam int MAG_W = PHI_W + 5;
   localparam int CMP_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
   localparam logic [PLO_W:0] ROUND = (PLO_W + 1)'(1) << 27;

   // configuration
   logic [23:0]             inv_focal_x_ff, inv_focal_y_ff;
   logic [15:0]             center_x_ff, center_y_ff;
   logic [31:0]             min_depth_ff;
   logic [15:0]             depth_scale_ff;
   logic [12:0]             image_width_ff;
   dbp_pkg::color_mode_type color_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_x_ff <= dbp_pkg::RST_INV_FOCAL_X;
         inv_focal_y_ff <= dbp_pkg::RST_INV_FOCAL_Y;
         center_x_ff    <= dbp_pkg::RST_CENTER_X;
         center_y_ff    <= dbp_pkg::RST_CENTER_Y;
         min_depth_ff   <= dbp_pkg::RST_MIN_DEPTH;
         depth_scale_ff <= dbp_pkg::RST_DEPTH_SCALE;
         image_width_ff <= dbp_pkg::RST_IMAGE_WIDTH;
         color_mode_ff  <= dbp_pkg::RST_COLOR_MODE;
      end else if (csr_valid) begin
         unique case (dbp_pkg::csr_index_type'(csr_index))
            dbp_pkg::CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_data[23:0];
            dbp_pkg::CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_data[23:0];
            dbp_pkg::CSR_CENTER_X:    center_x_ff    <= csr_data[15:0];
            dbp_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_data[15:0];
            dbp_pkg::CSR_MIN_DEPTH:   min_depth_ff   <= csr_data;
            dbp_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_data[15:0];
            dbp_pkg::CSR_IMAGE_WIDTH: image_width_ff <= csr_data[12:0];
            dbp_pkg::CSR_COLOR_MODE:
               color_mode_ff <= dbp_pkg::color_mode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // raster counters
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [COORD_BITS-1:0] col_use, row_use;
   logic [CMP_W-1:0]      next_col, width_ext, width_eff, width_max;

   always_comb begin
      col_use   = req_tuser[0] ? '0 : col_ff;
      row_use   = req_tuser[0] ? '0 : row_ff;
      next_col  = CMP_W'(col_use) + CMP_W'(1);
      width_ext = CMP_W'(image_width_ff);
      width_max = CMP_W'(1) << COORD_BITS;
      width_eff = (width_ext > width_max) ? width_max : width_ext;
      col_in    = col_ff;
      row_in    = row_ff;
      if (cmd.op == dbp_pkg::OP_CAPTURE) begin
         if (next_col >= width_eff) begin
            col_in = '0;
            row_in = row_use + COORD_BITS'(1);
         end else begin
            col_in = next_col[COORD_BITS-1:0];
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // per-pixel working registers
   logic [COORD_BITS-1:0] cur_col_ff, cur_row_ff;
   logic [15:0]           raw_ff;
   logic [7:0]            red_ff, green_ff, blue_ff;
   logic [7:0]            red_in, green_in, blue_in;
   logic [31:0]           z_ff, zeff_ff;
   logic                  valid_ff;
   logic                  neg_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [M_W-1:0]        m_ff;
   logic [PLO_W-1:0]      plo_ff;
   logic [PHI_W-1:0]      phi_ff;
   logic [31:0]           x_ff, y_ff;

   always_comb begin
      unique case (color_mode_ff)
         dbp_pkg::COLOR_BGR: begin
            red_in   = req_tdata[39:32];
            green_in = req_tdata[31:24];
            blue_in  = req_tdata[23:16];
         end
         dbp_pkg::COLOR_RGB: begin
            red_in   = req_tdata[23:16];
            green_in = req_tdata[31:24];
            blue_in  = req_tdata[39:32];
         end
         default: begin
            red_in   = req_tdata[23:16];
            green_in = req_tdata[23:16];
            blue_in  = req_tdata[23:16];
         end
      endcase
   end

   logic [COORD_BITS+3:0] p16;
   logic [OFF_W-1:0]      p16_ext, center_ext;
   logic [M_W-1:0]        m_in;
   logic [23:0]           inv_sel;
   logic [PLO_W:0]        lo_sum;
   logic [MAG_W-1:0]      mag;
   logic [31:0]           sat_val;

   always_comb begin
      p16        = {(cmd.axis_y ? cur_row_ff : cur_col_ff), 4'b0000};
      p16_ext    = OFF_W'(p16);
      center_ext = OFF_W'(cmd.axis_y ? center_y_ff : center_x_ff);
      m_in       = M_W'(off_ff) * M_W'(zeff_ff);
      inv_sel    = cmd.axis_y ? inv_focal_y_ff : inv_focal_x_ff;
      lo_sum     = (PLO_W + 1)'(plo_ff) + ROUND;
      mag        = MAG_W'({phi_ff, 4'b0000}) + MAG_W'(lo_sum[PLO_W:28]);
      if (neg_ff) begin
         sat_val = (mag[MAG_W-1:31] != '0) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      end else begin
         sat_val = (mag[MAG_W-1:31] != '0) ? 32'h7FFF_FFFF : mag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         dbp_pkg::OP_CAPTURE: begin
            cur_col_ff <= col_use;
            cur_row_ff <= row_use;
            raw_ff     <= req_tdata[15:0];
            red_ff     <= red_in;
            green_ff   <= green_in;
            blue_ff    <= blue_in;
         end
         dbp_pkg::OP_ZMUL: begin
            z_ff <= 32'(raw_ff) * 32'(depth_scale_ff);
         end
         dbp_pkg::OP_ZCMP: begin
            valid_ff <= z_ff >= min_depth_ff;
            zeff_ff  <= (z_ff >= min_depth_ff) ? z_ff : dbp_pkg::UNIT_Z;
         end
         dbp_pkg::OP_OFFSET: begin
            neg_ff <= p16_ext < center_ext;
            off_ff <= (p16_ext < center_ext) ? center_ext - p16_ext
                                             : p16_ext - center_ext;
         end
         dbp_pkg::OP_MUL: begin
            m_ff <= m_in;
         end
         dbp_pkg::OP_PROD: begin
            plo_ff <= PLO_W'(m_ff[31:0]) * PLO_W'(inv_sel);
            phi_ff <= PHI_W'(m_ff[M_W-1:32]) * PHI_W'(inv_sel);
         end
         dbp_pkg::OP_SAT: begin
            if (cmd.axis_y) begin
               y_ff <= sat_val;
            end else begin
               x_ff <= sat_val;
            end
         end
         default: ;
      endcase
   end

   // output register
   logic                  rsp_valid_ff;
   logic [143:0]          rsp_data_ff;
   logic                  rsp_user_ff;
   logic [15:0]           col_wide, row_wide;

   assign col_wide = 16'(cur_col_ff);
   assign row_wide = 16'(cur_row_ff);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == dbp_pkg::OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == dbp_pkg::OP_LOAD) begin
         rsp_data_ff <= {blue_ff, green_ff, red_ff, z_ff, y_ff, x_ff,
                         row_wide[dbp_pkg::PIX_W-1:0], col_wide[dbp_pkg::PIX_W-1:0]};
         rsp_user_ff <= valid_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

`default_nettype wire

// File: tb/depth_pixel_backprojection_core_tb.sv
`timescale 1ns / 1ps

module depth_pixel_backprojection_core_tb;

   localparam int CYCLE_LIMIT = 900000;
   localparam int SEG_ITEMS   = 120;
   localparam int WRAP_ITEMS  = 75;

   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        z_ok;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } point_type;

   typedef struct {
      logic [23:0]             inv_fx;
      logic [23:0]             inv_fy;
      logic [15:0]             cen_x;
      logic [15:0]             cen_y;
      logic [31:0]             z_min;
      logic [15:0]             z_scale;
      logic [12:0]             width;
      dbp_pkg::color_mode_type mode;
   } camera_cfg_type;

   class point_scoreboard;
      logic [23:0]             inv_fx;
      logic [23:0]             inv_fy;
      logic [15:0]             cen_x;
      logic [15:0]             cen_y;
      logic [31:0]             z_min;
      logic [15:0]             z_scale;
      logic [12:0]             width;
      dbp_pkg::color_mode_type mode;
      logic [11:0]             col;
      logic [11:0]             row;
      point_type               expected_q[$];
      int                      mismatches;
      int                      points_seen;

      function new();
         inv_fx      = dbp_pkg::RST_INV_FOCAL_X;
         inv_fy      = dbp_pkg::RST_INV_FOCAL_Y;
         cen_x       = dbp_pkg::RST_CENTER_X;
         cen_y       = dbp_pkg::RST_CENTER_Y;
         z_min       = dbp_pkg::RST_MIN_DEPTH;
         z_scale     = dbp_pkg::RST_DEPTH_SCALE;
         width       = dbp_pkg::RST_IMAGE_WIDTH;
         mode        = dbp_pkg::RST_COLOR_MODE;
         col         = '0;
         row         = '0;
         mismatches  = 0;
         points_seen = 0;
      endfunction

      function void write_reg(dbp_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            dbp_pkg::CSR_INV_FOCAL_X: inv_fx = v[23:0];
            dbp_pkg::CSR_INV_FOCAL_Y: inv_fy = v[23:0];
            dbp_pkg::CSR_CENTER_X:    cen_x = v[15:0];
            dbp_pkg::CSR_CENTER_Y:    cen_y = v[15:0];
            dbp_pkg::CSR_MIN_DEPTH:   z_min = v;
            dbp_pkg::CSR_DEPTH_SCALE: z_scale = v[15:0];
            dbp_pkg::CSR_IMAGE_WIDTH: width = v[12:0];
            dbp_pkg::CSR_COLOR_MODE:  mode = dbp_pkg::color_mode_type'(v[1:0]);
            default: ;
         endcase
      endfunction

      // (pos*16 - center) * zeff * inv >> 28, rounded half away, saturated
      function logic [31:0] backproject_axis(logic [11:0] pos, logic [15:0] center,
                                             logic [63:0] zeff, logic [23:0] inv);
         logic [63:0] p16;
         logic [63:0] c64;
         logic [63:0] inv64;
         logic [63:0] mag_off;
         logic [63:0] m;
         logic [63:0] mh;
         logic [63:0] ml;
         logic [63:0] c;
         logic [63:0] mag;
         logic        neg;
         p16     = {48'd0, pos, 4'd0};
         c64     = {48'd0, center};
         inv64   = {40'd0, inv};
         neg     = p16 < c64;
         mag_off = neg ? c64 - p16 : p16 - c64;
         m       = mag_off * zeff;
         mh      = m >> 32;
         ml      = m & 64'hFFFF_FFFF;
         c       = ml * inv64 + (64'd1 << 27);
         mag     = mh * inv64 * 64'd16 + (c >> 28);
         if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(64'h1_0000_0000 - mag);
         end
         if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return mag[31:0];
      endfunction

      function void note_pixel(logic first, logic [15:0] depth,
                               logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
         point_type   p;
         logic [63:0] zeff;
         logic [12:0] lim;
         logic [12:0] nxt;
         if (first) begin
            col = '0;
            row = '0;
         end
         p.z    = {16'd0, depth} * {16'd0, z_scale};
         p.z_ok = p.z >= z_min;
         zeff   = p.z_ok ? {32'd0, p.z} : {32'd0, dbp_pkg::UNIT_Z};
         case (mode)
            dbp_pkg::COLOR_BGR: begin
               p.red = c2; p.green = c1; p.blue = c0;
            end
            dbp_pkg::COLOR_RGB: begin
               p.red = c0; p.green = c1; p.blue = c2;
            end
            default: begin
               p.red = c0; p.green = c0; p.blue = c0;
            end
         endcase
         p.col = col;
         p.row = row;
         p.x   = backproject_axis(col, cen_x, zeff, inv_fx);
         p.y   = backproject_axis(row, cen_y, zeff, inv_fy);
         expected_q.push_back(p);
         lim = (width > 13'd4096) ? 13'd4096 : width;
         nxt = {1'b0, col} + 13'd1;
         if (nxt >= lim) begin
            col = '0;
            row = row + 12'd1;
         end else begin
            col = nxt[11:0];
         end
      endfunction

      function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            if (mismatches < 10)
               $display("point %0d %s: expected %h, actual %h",
                        points_seen, what, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_point(logic [143:0] data, logic [0:0] user);
         point_type p;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("point %0d: unexpected transfer, data %h", points_seen, data);
            mismatches++;
         end else begin
            p = expected_q.pop_front();
            report("pixel_col", 32'(p.col), 32'(data[11:0]));
            report("pixel_row", 32'(p.row), 32'(data[23:12]));
            report("x_pos", p.x, data[55:24]);
            report("y_pos", p.y, data[87:56]);
            report("z_pos", p.z, data[119:88]);
            report("z_valid", 32'(p.z_ok), 32'(user[0]));
            report("red", 32'(p.red), 32'(data[127:120]));
            report("green", 32'(p.green), 32'(data[135:128]));
            report("blue", 32'(p.blue), 32'(data[143:136]));
         end
         points_seen++;
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;   // depth_raw, chan_zero, chan_one, chan_two
   logic [0:0]   req_tuser = '0;   // first_of_frame
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;        // pixel_col, pixel_row, x_pos, y_pos, z_pos,
                                   // red, green, blue
   logic [0:0]   rsp_tuser;        // z_valid
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   int cycle_count = 0;
   int send_idle_pct = 8;
   int recv_idle_pct = 62;

   point_scoreboard sb = new();

   depth_pixel_backprojection_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_point(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_pixel(input logic first, input logic [15:0] depth,
                             input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c2, c1, c0, depth};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(first, depth, c0, c1, c2);
   endtask

   // hold the input until every point has come back
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic put_reg(input dbp_pkg::csr_index_type idx, input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task automatic write_config(input camera_cfg_type cfg);
      put_reg(dbp_pkg::CSR_INV_FOCAL_X, 32'(cfg.inv_fx));
      put_reg(dbp_pkg::CSR_INV_FOCAL_Y, 32'(cfg.inv_fy));
      put_reg(dbp_pkg::CSR_CENTER_X, 32'(cfg.cen_x));
      put_reg(dbp_pkg::CSR_CENTER_Y, 32'(cfg.cen_y));
      put_reg(dbp_pkg::CSR_MIN_DEPTH, cfg.z_min);
      put_reg(dbp_pkg::CSR_DEPTH_SCALE, 32'(cfg.z_scale));
      put_reg(dbp_pkg::CSR_IMAGE_WIDTH, 32'(cfg.width));
      put_reg(dbp_pkg::CSR_COLOR_MODE, 32'(cfg.mode));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_depth();
      case ($urandom_range(15))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic camera_cfg_type random_cfg();
      camera_cfg_type cfg;
      cfg.inv_fx  = $urandom_range(1) ? 24'($urandom_range(20000, 40000)) : 24'($urandom);
      cfg.inv_fy  = $urandom_range(1) ? 24'($urandom_range(20000, 40000)) : 24'($urandom);
      cfg.cen_x   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      cfg.cen_y   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      cfg.z_min   = $urandom >> $urandom_range(0, 16);
      cfg.z_scale = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1000, 10000));
      case ($urandom_range(9))
         0: cfg.width = 13'd0;
         1: cfg.width = 13'($urandom_range(4096, 8191));
         2: cfg.width = 13'($urandom_range(49, 4096));
         default: cfg.width = 13'($urandom_range(1, 48));
      endcase
      cfg.mode = dbp_pkg::color_mode_type'($urandom_range(0, 3));
      return cfg;
   endfunction

   task automatic run_random(input int count, input logic frames);
      int   n;
      logic first;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(199) == 0) settle(0);
         first = (n == 0) || (frames && $urandom_range(49) == 0);
         send_pixel(first, pick_depth(), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_directed();
      camera_cfg_type          cfg;
      dbp_pkg::color_mode_type modes[4];
      int                      k;
      modes = '{dbp_pkg::COLOR_BGR, dbp_pkg::COLOR_RGB, dbp_pkg::COLOR_GRAY,
                dbp_pkg::COLOR_RSVD};
      cfg.inv_fx  = dbp_pkg::RST_INV_FOCAL_X;
      cfg.inv_fy  = dbp_pkg::RST_INV_FOCAL_Y;
      cfg.cen_x   = dbp_pkg::RST_CENTER_X;
      cfg.cen_y   = dbp_pkg::RST_CENTER_Y;
      cfg.z_min   = dbp_pkg::RST_MIN_DEPTH;
      cfg.z_scale = dbp_pkg::RST_DEPTH_SCALE;
      cfg.width   = dbp_pkg::RST_IMAGE_WIDTH;
      for (k = 0; k < 4; k++) begin
         cfg.mode = modes[k];
         if (k != 0) write_config(cfg);
         // depth zero, full scale, just below and at the threshold
         send_pixel(1'b1, 16'd0, 8'h00, 8'h00, 8'h00);
         send_pixel(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
         send_pixel(1'b0, 16'd4, 8'h01, 8'h80, 8'h7F);
         send_pixel(1'b0, 16'd5, 8'hA5, 8'h5A, 8'hC3);
         send_pixel(1'b0, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         settle(16);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      camera_cfg_type cfg;
      int             seg;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (seg = 0; seg < 9; seg++) begin
         send_idle_pct = (seg < 3) ? 8 : (seg < 6) ? 62 : 0;
         recv_idle_pct = (seg < 3) ? 62 : (seg < 6) ? 8 : 0;
         cfg = random_cfg();
         if (seg == 0) begin
            cfg.inv_fx  = 24'hFF_FFFF;
            cfg.inv_fy  = 24'hFF_FFFF;
            cfg.cen_x   = 16'hFFFF;
            cfg.cen_y   = 16'hFFFF;
            cfg.z_min   = 32'hFFFF_FFFF;
            cfg.z_scale = 16'hFFFF;
            cfg.width   = 13'h1FFF;
            cfg.mode    = dbp_pkg::COLOR_RSVD;
         end else if (seg == 3) begin
            cfg.inv_fx  = '0;
            cfg.inv_fy  = '0;
            cfg.cen_x   = '0;
            cfg.cen_y   = '0;
            cfg.z_min   = '0;
            cfg.z_scale = '0;
            cfg.width   = '0;
            cfg.mode    = dbp_pkg::COLOR_BGR;
         end else if (seg == 6) begin
            // large z with far-off centers drives both saturation limits
            cfg.inv_fx  = 24'hFF_FFFF;
            cfg.inv_fy  = 24'hFF_FFFF;
            cfg.cen_x   = '0;
            cfg.cen_y   = 16'hFFFF;
            cfg.z_min   = '0;
            cfg.z_scale = 16'hFFFF;
            cfg.width   = 13'd4096;
            cfg.mode    = dbp_pkg::COLOR_GRAY;
         end
         settle(16);
         write_config(cfg);
         run_random(SEG_ITEMS, 1'b1);
      end
      // one pixel per row
      cfg = random_cfg();
      cfg.width = 13'd1;
      settle(16);
      write_config(cfg);
      run_random(WRAP_ITEMS, 1'b0);
      // width above the counter range
      cfg = random_cfg();
      cfg.width = 13'h1FFF;
      settle(16);
      write_config(cfg);
      run_random(WRAP_ITEMS, 1'b0);
      settle(24);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/dbp_pkg.sv
src/dbp_ctrl.sv
src/dbp_datapath.sv
src/depth_pixel_backprojection_core.sv
tb/depth_pixel_backprojection_core_tb.sv
